@@ sv/bzw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzw_pkg
// Shared constants, codes and types of the Bezier wavetable render and lookup.
// ----------------------------------------------------------------------------
package bzw_pkg;

	localparam int TABLE_DEPTH      = 1024;
	localparam int ADDR_W           = $clog2(TABLE_DEPTH);
	localparam int SIZE_W           = 11;
	localparam int MAX_NEWTON_STEPS = 16;
	localparam int K_W              = $clog2(MAX_NEWTON_STEPS + 1);
	localparam int AMP_W            = 16;
	localparam int CX_W             = 15;
	localparam int TOL_W            = 16;
	localparam int PHASE_W          = 16;
	localparam int STATUS_W         = 2;
	localparam int IDX_W            = 3;
	localparam int MUL_W            = 24;
	localparam int PROD_W           = 2 * MUL_W;
	localparam int TV_W             = 18;
	localparam int PV_W             = 20;
	localparam int QUO_W            = 40;
	localparam int DEN_W            = 24;
	localparam int DCNT_W           = $clog2(QUO_W + 1);

	localparam logic CMD_RENDER = 1'b0;
	localparam logic CMD_APPLY  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_APPLIED  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RENDERED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;

	localparam logic [IDX_W-1:0] REG_START_LEVEL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_END_LEVEL     = 3'd1;
	localparam logic [IDX_W-1:0] REG_FIRST_CTRL_X  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FIRST_CTRL_Y  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SECOND_CTRL_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_SECOND_CTRL_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_TABLE_SIZE    = 3'd6;
	localparam logic [IDX_W-1:0] REG_NEWTON_TOL    = 3'd7;

	typedef struct packed {
		logic signed [AMP_W-1:0] start_level;
		logic signed [AMP_W-1:0] end_level;
		logic [CX_W-1:0]         first_ctrl_x;
		logic signed [AMP_W-1:0] first_ctrl_y;
		logic [CX_W-1:0]         second_ctrl_x;
		logic signed [AMP_W-1:0] second_ctrl_y;
		logic [TOL_W-1:0]        newton_tolerance;
	} bzw_cfg_t;

	typedef struct packed {
		logic                    en;
		logic [ADDR_W-1:0]       addr;
		logic signed [AMP_W-1:0] data;
	} bzw_wr_t;

endpackage

@@ sv/bzw_render.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzw_render
// Table render sequencer: Newton solve and Horner evaluation per entry on one
// shared multiplier and one radix-2 divider.
// ----------------------------------------------------------------------------
module bzw_render (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bzw_pkg::SIZE_W-1:0]    size,
	input  bzw_pkg::bzw_cfg_t             cfg,
	output bzw_pkg::bzw_wr_t              wr,
	output logic                          done
);

	localparam logic [3:0] E_IDLE = 4'd0;
	localparam logic [3:0] E_PDIV = 4'd1;
	localparam logic [3:0] E_MUL  = 4'd2;
	localparam logic [3:0] E_WB   = 4'd3;
	localparam logic [3:0] E_CHK  = 4'd4;
	localparam logic [3:0] E_NDIV = 4'd5;
	localparam logic [3:0] E_HMUL = 4'd6;
	localparam logic [3:0] E_HWB  = 4'd7;
	localparam logic [3:0] E_DONE = 4'd8;

	localparam logic [3:0] OP_T2  = 4'd0;
	localparam logic [3:0] OP_TI2 = 4'd1;
	localparam logic [3:0] OP_T3  = 4'd2;
	localparam logic [3:0] OP_P1  = 4'd3;
	localparam logic [3:0] OP_P2  = 4'd4;
	localparam logic [3:0] OP_F1  = 4'd5;
	localparam logic [3:0] OP_F2  = 4'd6;
	localparam logic [3:0] OP_D1  = 4'd7;
	localparam logic [3:0] OP_D2  = 4'd8;

	localparam int MW = bzw_pkg::MUL_W;
	localparam int TW = bzw_pkg::TV_W;
	localparam int QW = bzw_pkg::QUO_W;
	localparam int DW = bzw_pkg::DEN_W;
	localparam logic [TW-1:0] ONE_T = TW'(65536);

	logic [3:0]                       state_q, state_d;
	logic [3:0]                       op_q;
	logic [1:0]                       r_q;
	logic [bzw_pkg::K_W-1:0]          k_q;
	logic [bzw_pkg::SIZE_W-1:0]       i_q;
	logic signed [TW-1:0]             t_q, t2_q, ti2_q, t3_q, pos_q;
	logic signed [bzw_pkg::PV_W-1:0]  p1_q, p2_q;
	logic signed [MW-1:0]             f_q, d_q, h_q;
	logic signed [bzw_pkg::PROD_W-1:0] prod_q;
	logic [DW:0]                      dv_rem_q;
	logic [QW-1:0]                    dv_quo_q;
	logic [DW-1:0]                    dv_den_q;
	logic [bzw_pkg::DCNT_W-1:0]       dv_cnt_q;
	logic                             dv_neg_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [MW-1:0] ti, ax, bx, ax3, bx3, u1, u2, t2x3;
	logic signed [MW-1:0] s, e, ay, by, c0, c1, c2, c3, csel, h_next;
	logic signed [MW-1:0] sh14, sh16;
	logic [DW:0]          dv_shift;
	logic                 dv_fit, dv_end;
	logic signed [QW:0]   step;
	logic signed [QW+1:0] t_new;
	logic signed [TW-1:0] t_clamp;
	logic [DW-1:0]        f_mag, d_mag;
	logic [bzw_pkg::SIZE_W-1:0] i_next;
	logic                 newton_stop, last_entry;

	assign ti   = MW'(ONE_T - t_q);
	assign ax   = $signed({{(MW-bzw_pkg::CX_W){1'b0}}, cfg.first_ctrl_x});
	assign bx   = $signed({{(MW-bzw_pkg::CX_W){1'b0}}, cfg.second_ctrl_x});
	assign ax3  = ax + (ax <<< 1);
	assign bx3  = bx + (bx <<< 1);
	assign t2x3 = MW'(t2_q) + (MW'(t2_q) <<< 1);
	assign u1   = MW'(ONE_T) - (MW'(t_q) <<< 2) + t2x3;
	assign u2   = (MW'(t_q) <<< 1) - t2x3;

	assign s  = MW'(cfg.start_level);
	assign e  = MW'(cfg.end_level);
	assign ay = MW'(cfg.first_ctrl_y);
	assign by = MW'(cfg.second_ctrl_y);
	assign c0 = s;
	assign c1 = (ay + (ay <<< 1)) - (s + (s <<< 1));
	assign c2 = (s + (s <<< 1)) - (ay <<< 2) - (ay <<< 1) + (by + (by <<< 1));
	assign c3 = e - s + (ay + (ay <<< 1)) - (by + (by <<< 1));

	assign sh14 = $signed(prod_q[37:14]);
	assign sh16 = $signed(prod_q[39:16]);

	always_comb begin
		case (r_q)
			2'd0:    csel = c2;
			2'd1:    csel = c1;
			default: csel = c0;
		endcase
	end
	assign h_next = csel + sh16;

	always_comb begin
		mul_a = MW'(t_q);
		mul_b = MW'(t_q);
		if (state_q == E_HMUL) begin
			mul_b = h_q;
		end else begin
			case (op_q)
				OP_T2: begin
					mul_a = MW'(t_q);
					mul_b = MW'(t_q);
				end
				OP_TI2: begin
					mul_a = ti;
					mul_b = ti;
				end
				OP_T3: begin
					mul_a = MW'(t2_q);
					mul_b = MW'(t_q);
				end
				OP_P1: begin
					mul_a = MW'(ti2_q) + (MW'(ti2_q) <<< 1);
					mul_b = MW'(t_q);
				end
				OP_P2: begin
					mul_a = ti + (ti <<< 1);
					mul_b = MW'(t2_q);
				end
				OP_F1: begin
					mul_a = MW'(p1_q);
					mul_b = ax;
				end
				OP_F2: begin
					mul_a = MW'(p2_q);
					mul_b = bx;
				end
				OP_D1: begin
					mul_a = ax3;
					mul_b = u1;
				end
				OP_D2: begin
					mul_a = bx3;
					mul_b = u2;
				end
				default: begin
					mul_a = MW'(t_q);
					mul_b = MW'(t_q);
				end
			endcase
		end
	end

	assign dv_shift = {dv_rem_q[DW-1:0], dv_quo_q[QW-1]};
	assign dv_fit   = dv_shift >= {1'b0, dv_den_q};
	assign dv_end   = dv_cnt_q == bzw_pkg::DCNT_W'(QW);

	assign step    = dv_neg_q ? -$signed({1'b0, dv_quo_q}) : $signed({1'b0, dv_quo_q});
	assign t_new   = (QW+2)'(t_q) - (QW+2)'(step);
	assign t_clamp = (t_new < 0) ? '0 :
		(t_new > (QW+2)'(65536)) ? $signed(ONE_T) : t_new[TW-1:0];
	assign newton_stop = (dv_quo_q <= QW'(cfg.newton_tolerance)) ||
		(k_q == bzw_pkg::K_W'(bzw_pkg::MAX_NEWTON_STEPS - 1));

	assign f_mag  = f_q[MW-1] ? DW'(-f_q) : DW'(f_q);
	assign d_mag  = d_q[MW-1] ? DW'(-d_q) : DW'(d_q);
	assign i_next = i_q + 1'b1;
	assign last_entry = i_next == size;

	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE: if (start) state_d = (size == '0) ? E_DONE : E_PDIV;
			E_PDIV: if (dv_end) state_d = (i_q == '0) ? E_HMUL : E_MUL;
			E_MUL:  state_d = E_WB;
			E_WB:   state_d = (op_q == OP_D2) ? E_CHK : E_MUL;
			E_CHK:  state_d = (d_q == '0) ? E_HMUL : E_NDIV;
			E_NDIV: if (dv_end) state_d = newton_stop ? E_HMUL : E_MUL;
			E_HMUL: state_d = E_HWB;
			E_HWB: begin
				if (r_q == 2'd2) state_d = last_entry ? E_DONE : E_PDIV;
				else state_d = E_HMUL;
			end
			E_DONE: state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if ((state_q == E_PDIV || state_q == E_NDIV) && !dv_end) begin
			dv_rem_q <= dv_fit ? dv_shift - {1'b0, dv_den_q} : dv_shift;
			dv_quo_q <= {dv_quo_q[QW-2:0], dv_fit};
			dv_cnt_q <= dv_cnt_q + 1'b1;
		end
		case (state_q)
			E_IDLE: begin
				i_q      <= '0;
				dv_rem_q <= '0;
				dv_quo_q <= '0;
				dv_den_q <= DW'(size);
				dv_cnt_q <= '0;
				dv_neg_q <= 1'b0;
			end
			E_PDIV: begin
				if (dv_end) begin
					pos_q <= $signed({2'b00, dv_quo_q[15:0]});
					t_q   <= (i_q == '0) ? '0 : $signed({2'b00, dv_quo_q[15:0]});
					op_q  <= OP_T2;
					k_q   <= '0;
					h_q   <= c3;
					r_q   <= 2'd0;
				end
			end
			E_WB: begin
				case (op_q)
					OP_T2:   t2_q  <= $signed(prod_q[33:16]);
					OP_TI2:  ti2_q <= $signed(prod_q[33:16]);
					OP_T3:   t3_q  <= $signed(prod_q[33:16]);
					OP_P1:   p1_q  <= $signed(prod_q[35:16]);
					OP_P2:   p2_q  <= $signed(prod_q[35:16]);
					OP_F1:   f_q   <= sh14;
					OP_F2:   f_q   <= f_q + sh14 + MW'(t3_q) - MW'(pos_q);
					OP_D1:   d_q   <= sh14;
					OP_D2:   d_q   <= d_q + sh14 + t2x3;
					default: f_q   <= f_q;
				endcase
				op_q <= op_q + 1'b1;
			end
			E_CHK: begin
				h_q      <= c3;
				r_q      <= 2'd0;
				dv_rem_q <= '0;
				dv_quo_q <= {f_mag, 16'b0};
				dv_den_q <= d_mag;
				dv_cnt_q <= '0;
				dv_neg_q <= f_q[MW-1] ^ d_q[MW-1];
			end
			E_NDIV: begin
				if (dv_end) begin
					t_q  <= t_clamp;
					k_q  <= k_q + 1'b1;
					op_q <= OP_T2;
					h_q  <= c3;
					r_q  <= 2'd0;
				end
			end
			E_HWB: begin
				h_q <= h_next;
				r_q <= r_q + 1'b1;
				if (r_q == 2'd2) begin
					i_q      <= i_next;
					dv_rem_q <= '0;
					dv_quo_q <= {{(QW-bzw_pkg::SIZE_W-16){1'b0}}, i_next, 16'b0};
					dv_den_q <= DW'(size);
					dv_cnt_q <= '0;
					dv_neg_q <= 1'b0;
				end
			end
			default: r_q <= r_q;
		endcase
	end

	always_comb begin
		wr.en   = (state_q == E_HWB) && (r_q == 2'd2);
		wr.addr = i_q[bzw_pkg::ADDR_W-1:0];
		if (h_next > MW'(32767)) wr.data = 16'sh7FFF;
		else if (h_next < -MW'(32768)) wr.data = 16'sh8000;
		else wr.data = h_next[bzw_pkg::AMP_W-1:0];
	end

	assign done = state_q == E_DONE;

endmodule

@@ sv/bezier_wavetable_render_and_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_wavetable_render_and_lookup
// Cubic Bezier wavetable: render the table from the curve, look up and add.
// ----------------------------------------------------------------------------
// Apply: read, look-up and pending states, then the output register (an empty
//   table goes straight to pending); next word taken once the result is there.
// Render: per entry a position division, then k Newton steps (at most 16) and a
//   Horner pass on the radix-2 divider and the shared multiplier; then one result word.
// One item in flight; the table RAM (one write, one registered read) holds state.
// Reset clears control, loads default configuration; table undefined until rendered.
module bezier_wavetable_render_and_lookup (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bzw_pkg::IDX_W-1:0]        cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [bzw_pkg::PHASE_W-1:0]      phase,
	input  logic signed [bzw_pkg::AMP_W-1:0] amplitude_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [bzw_pkg::AMP_W-1:0] amplitude_out,
	output logic [bzw_pkg::STATUS_W-1:0]     status
);

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_READ = 3'd1;
	localparam logic [2:0] T_LOOK = 3'd2;
	localparam logic [2:0] T_REND = 3'd3;
	localparam logic [2:0] T_PEND = 3'd4;

	localparam int AW = bzw_pkg::AMP_W;
	localparam int SW = bzw_pkg::SIZE_W;

	logic [2:0]                        state_q;
	bzw_pkg::bzw_cfg_t                 cfg_q;
	logic [SW-1:0]                     size_q;
	logic [SW-1:0]                     n_eff;
	logic                              accept, slot_free, rend_done;
	bzw_pkg::bzw_wr_t                  wr;
	logic [bzw_pkg::ADDR_W-1:0]        idx_q;
	logic signed [AW-1:0]              amp_q, rd_q, pend_amp_q;
	logic [bzw_pkg::STATUS_W-1:0]      pend_stat_q;
	logic signed [AW-1:0]              wavetable_q [bzw_pkg::TABLE_DEPTH];
	logic [bzw_pkg::PHASE_W+SW-1:0]    idx_prod;
	logic signed [AW:0]                sum;
	logic signed [AW-1:0]              sum_sat;

	assign n_eff = (size_q > SW'(bzw_pkg::TABLE_DEPTH)) ? SW'(bzw_pkg::TABLE_DEPTH) : size_q;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != T_IDLE;
	assign slot_free = !out_valid || !out_stall;
	assign idx_prod  = phase * n_eff;
	assign sum       = (AW+1)'(amp_q) + (AW+1)'(rd_q);
	assign sum_sat   = (sum > (AW+1)'(32767)) ? 16'sh7FFF :
		(sum < -(AW+1)'(32768)) ? 16'sh8000 : sum[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_level      <= '0;
			cfg_q.end_level        <= '0;
			cfg_q.first_ctrl_x     <= 15'd5461;
			cfg_q.first_ctrl_y     <= '0;
			cfg_q.second_ctrl_x    <= 15'd10923;
			cfg_q.second_ctrl_y    <= '0;
			cfg_q.newton_tolerance <= 16'd4;
			size_q                 <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bzw_pkg::REG_START_LEVEL:   cfg_q.start_level   <= cfg_data;
				bzw_pkg::REG_END_LEVEL:     cfg_q.end_level     <= cfg_data;
				bzw_pkg::REG_FIRST_CTRL_X:  cfg_q.first_ctrl_x  <= cfg_data[14:0];
				bzw_pkg::REG_FIRST_CTRL_Y:  cfg_q.first_ctrl_y  <= cfg_data;
				bzw_pkg::REG_SECOND_CTRL_X: cfg_q.second_ctrl_x <= cfg_data[14:0];
				bzw_pkg::REG_SECOND_CTRL_Y: cfg_q.second_ctrl_y <= cfg_data;
				bzw_pkg::REG_TABLE_SIZE:    size_q              <= cfg_data[SW-1:0];
				bzw_pkg::REG_NEWTON_TOL:    cfg_q.newton_tolerance <= cfg_data;
				default:                    size_q              <= size_q;
			endcase
		end
	end

	bzw_render u_render (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && command == bzw_pkg::CMD_RENDER),
		.size   (n_eff),
		.cfg    (cfg_q),
		.wr     (wr),
		.done   (rend_done)
	);

	always_ff @(posedge clk) begin
		if (wr.en) wavetable_q[wr.addr] <= wr.data;
		if (state_q == T_READ) rd_q <= wavetable_q[idx_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amp_q       <= amplitude_in;
			idx_q       <= idx_prod[bzw_pkg::PHASE_W +: bzw_pkg::ADDR_W];
			pend_amp_q  <= amplitude_in;
			pend_stat_q <= bzw_pkg::STAT_EMPTY;
		end
		if (state_q == T_LOOK) begin
			pend_amp_q  <= sum_sat;
			pend_stat_q <= bzw_pkg::STAT_APPLIED;
		end
		if (state_q == T_REND && rend_done) begin
			pend_amp_q  <= '0;
			pend_stat_q <= bzw_pkg::STAT_RENDERED;
		end
		if (state_q == T_PEND && slot_free) begin
			amplitude_out <= pend_amp_q;
			status        <= pend_stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (command == bzw_pkg::CMD_RENDER) state_q <= T_REND;
						else if (n_eff == '0) state_q <= T_PEND;
						else state_q <= T_READ;
					end
				end
				T_READ: state_q <= T_LOOK;
				T_LOOK: state_q <= T_PEND;
				T_REND: if (rend_done) state_q <= T_PEND;
				T_PEND: begin
					if (slot_free) begin
						out_valid <= 1'b1;
						state_q   <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

endmodule

@@ sv/bzw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzw_checker
// Port-level checks of the wavetable block, bound to the top level.
// ----------------------------------------------------------------------------
module bzw_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [bzw_pkg::AMP_W-1:0] amplitude_out,
	input logic [bzw_pkg::STATUS_W-1:0]     status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(amplitude_out) && $stable(status))
		else $error("result word changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == bzw_pkg::STAT_APPLIED || status == bzw_pkg::STAT_RENDERED ||
			status == bzw_pkg::STAT_EMPTY)
		else $error("status code out of range");

	a_render_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bzw_pkg::STAT_RENDERED |-> amplitude_out == '0)
		else $error("render word carries an amplitude");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while one is in flight");

endmodule

bind bezier_wavetable_render_and_lookup bzw_checker u_bzw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.amplitude_out (amplitude_out),
	.status        (status)
);
